// ===== src/bcr_pkg.sv =====
// Shared types and constants for the bank controller with real-time clock.
// Used by bcr_ctrl, bcr_div, bcr_dp and bank_controller_with_rtc_top.
package bcr_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int MEM_ADDR_W     = 21;

  // Bus function codes.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Result target codes.
  localparam logic [1:0] TGT_LOCAL   = 2'd0;
  localparam logic [1:0] TGT_ROM_RD  = 2'd1;
  localparam logic [1:0] TGT_RAM_RD  = 2'd2;
  localparam logic [1:0] TGT_RAM_WR  = 2'd3;

  // Clock register select codes.
  localparam logic [2:0] RTC_SEC = 3'd0;
  localparam logic [2:0] RTC_MIN = 3'd1;
  localparam logic [2:0] RTC_HR  = 3'd2;
  localparam logic [2:0] RTC_DAY = 3'd3;
  localparam logic [2:0] RTC_CTL = 3'd4;

  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [6:0] ROM_BANK_MSK = 7'h7F;
  localparam logic [7:0] RAM_BANK_MAX = 8'h03;
  localparam logic [7:0] RTC_SEL_LO   = 8'h08;
  localparam logic [7:0] RTC_SEL_HI   = 8'h0C;
  localparam logic [7:0] LATCH_ONE    = 8'h01;
  localparam logic [7:0] SEC_MAX      = 8'h3B;
  localparam logic [7:0] HR_MAX       = 8'h17;
  localparam logic [7:0] HALT_MSK     = 8'h40;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;

  // Latch arithmetic.
  localparam int PART_W    = 21;
  localparam int DAYP_W    = 25;
  localparam int TOTAL_W   = 33;
  localparam int REM_W     = 6;
  localparam logic [REM_W-1:0] DIV_SIXTY = 6'd60;
  localparam logic [REM_W-1:0] DIV_DAY   = 6'd24;
  localparam int SEC_PER_MIN = 60;
  localparam int SEC_PER_HR  = 3600;
  localparam int SEC_PER_DAY = 86400;

  // Reciprocal division: x/60 = ((x>>2) * ceil(2^35/15)) >> 35 and
  // x/24 = ((x>>3) * ceil(2^33/3)) >> 33, exact for a shifted operand below 2^31.
  localparam int MUL_A_W = 31;
  localparam int RECIP_W = 32;
  localparam int PROD_W  = MUL_A_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_FIFTEEN = 32'h8888_8889;
  localparam logic [RECIP_W-1:0] RECIP_THREE   = 32'hAAAA_AAAB;
  localparam int SHIFT_FIFTEEN = 35;
  localparam int SHIFT_THREE   = 33;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            target;
    logic [MEM_ADDR_W-1:0] mem_address;
    logic [7:0]            data;
  } out_item_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_EXEC    = 10'b00_0000_0010,
    ST_SUM     = 10'b00_0000_0100,
    ST_LD_SEC  = 10'b00_0000_1000,
    ST_DIV_SEC = 10'b00_0001_0000,
    ST_LD_MIN  = 10'b00_0010_0000,
    ST_DIV_MIN = 10'b00_0100_0000,
    ST_LD_HR   = 10'b00_1000_0000,
    ST_DIV_HR  = 10'b01_0000_0000,
    ST_COMMIT  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sum;
    logic ld_sec;
    logic ld_min;
    logic ld_hr;
    logic step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic latch_go;
    logic div_done;
  } sts_t;

endpackage

// ===== src/bank_controller_with_rtc_top.sv =====
// Cartridge bank controller with real-time clock: top level; uses bcr_pkg, bcr_ctrl, bcr_dp.
// A beat is captured from in_item while idle, executed in the next state, and its result is
//   strobed on out_ from a register; the next beat is taken at the edge that accepts that result.
// A firing clock latch keeps busy high through the sum, three reciprocal divisions,
//   each behind a load state, and the write-back; no new beat is taken until it ends.
// Reset (rst_n low, synchronous): ROM bank 1, mapper and clock state cleared, no strobe; receiver never stalls.
module bank_controller_with_rtc_top #(
  parameter int ROM_BANK_BYTES = bcr_pkg::ROM_BANK_BYTES,
  parameter int RAM_BANK_BYTES = bcr_pkg::RAM_BANK_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bcr_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output bcr_pkg::out_item_t  out_item
);

  // Command and status between the sequencer and the datapath.
  bcr_pkg::cmd_t cmd;
  bcr_pkg::sts_t sts;

  // Sequencer: capture a beat when idle, then execute it; a firing latch
  // walks through the sum, three divider passes and the write-back.
  bcr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: hold the mapper and clock state, map addresses, answer reads
  // locally and drive the registered result beat.
  bcr_dp #(
    .ROM_BANK_BYTES (ROM_BANK_BYTES),
    .RAM_BANK_BYTES (RAM_BANK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== src/bcr_ctrl.sv =====
// Sequencer for the bank controller: accepts beats and steps the latch pass.
// Depends on bcr_pkg.
module bcr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bcr_pkg::sts_t sts,
  output bcr_pkg::cmd_t cmd,
  output logic          busy
);

  bcr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcr_pkg::ST_IDLE: begin
        if (start) state_nxt = bcr_pkg::ST_EXEC;
      end
      bcr_pkg::ST_EXEC: begin
        state_nxt = sts.latch_go ? bcr_pkg::ST_SUM : bcr_pkg::ST_IDLE;
      end
      bcr_pkg::ST_SUM:    state_nxt = bcr_pkg::ST_LD_SEC;
      bcr_pkg::ST_LD_SEC: state_nxt = bcr_pkg::ST_DIV_SEC;
      bcr_pkg::ST_DIV_SEC: begin
        if (sts.div_done) state_nxt = bcr_pkg::ST_LD_MIN;
      end
      bcr_pkg::ST_LD_MIN: state_nxt = bcr_pkg::ST_DIV_MIN;
      bcr_pkg::ST_DIV_MIN: begin
        if (sts.div_done) state_nxt = bcr_pkg::ST_LD_HR;
      end
      bcr_pkg::ST_LD_HR: state_nxt = bcr_pkg::ST_DIV_HR;
      bcr_pkg::ST_DIV_HR: begin
        if (sts.div_done) state_nxt = bcr_pkg::ST_COMMIT;
      end
      bcr_pkg::ST_COMMIT: state_nxt = bcr_pkg::ST_IDLE;
      default:            state_nxt = bcr_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != bcr_pkg::ST_IDLE);

  always_comb begin
    cmd.capture = start && (state_r == bcr_pkg::ST_IDLE);
    cmd.exec    = (state_r == bcr_pkg::ST_EXEC);
    cmd.sum     = (state_r == bcr_pkg::ST_SUM);
    cmd.ld_sec  = (state_r == bcr_pkg::ST_LD_SEC);
    cmd.ld_min  = (state_r == bcr_pkg::ST_LD_MIN);
    cmd.ld_hr   = (state_r == bcr_pkg::ST_LD_HR);
    cmd.step    = (state_r == bcr_pkg::ST_DIV_SEC) || (state_r == bcr_pkg::ST_DIV_MIN) ||
                  (state_r == bcr_pkg::ST_DIV_HR);
    cmd.commit  = (state_r == bcr_pkg::ST_COMMIT);
    cmd.emit    = (cmd.exec && !sts.latch_go) || cmd.commit;
  end

endmodule

// ===== src/bcr_div.sv =====
// Divider by a small constant (60 or 24) through reciprocal multiplication:
// the first step registers the product, the second reads out quotient and remainder.
// Depends on bcr_pkg.
module bcr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              sel_day,
  input  logic                              step,
  input  logic [bcr_pkg::TOTAL_W-1:0]       dividend,
  output logic                              done,
  output logic [bcr_pkg::TOTAL_W-1:0]       quot,
  output logic [bcr_pkg::REM_W-1:0]         rem
);

  logic [bcr_pkg::TOTAL_W-1:0] x_r;
  logic                        day_r;
  logic                        ph_r;
  logic [bcr_pkg::PROD_W-1:0]  prod_r;
  logic [bcr_pkg::MUL_A_W-1:0] mul_a;
  logic [bcr_pkg::RECIP_W-1:0] mul_b;
  logic [bcr_pkg::REM_W-1:0]   dvs;
  logic [bcr_pkg::REM_W-1:0]   qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 1'b0;
    end else if (load) begin
      ph_r <= 1'b0;
    end else if (step) begin
      ph_r <= 1'b1;
    end
  end

  // Drop the low bits of 60 or 24 first, then multiply by the reciprocal.
  assign mul_a = day_r ? {1'b0, x_r[bcr_pkg::TOTAL_W-1:3]} : x_r[bcr_pkg::TOTAL_W-1:2];
  assign mul_b = day_r ? bcr_pkg::RECIP_THREE : bcr_pkg::RECIP_FIFTEEN;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r   <= dividend;
      day_r <= sel_day;
    end
    if (step && !ph_r) begin
      prod_r <= bcr_pkg::PROD_W'(mul_a) * bcr_pkg::PROD_W'(mul_b);
    end
  end

  assign quot = day_r ? bcr_pkg::TOTAL_W'(prod_r >> bcr_pkg::SHIFT_THREE)
                      : bcr_pkg::TOTAL_W'(prod_r >> bcr_pkg::SHIFT_FIFTEEN);

  // The remainder is below 64, so the low bits of x - q*d are enough.
  assign dvs  = day_r ? bcr_pkg::DIV_DAY : bcr_pkg::DIV_SIXTY;
  assign qd   = quot[bcr_pkg::REM_W-1:0] * dvs;
  assign rem  = x_r[bcr_pkg::REM_W-1:0] - qd;

  assign done = step && ph_r;

endmodule

// ===== src/bcr_dp.sv =====
// Datapath: mapper state, clock registers, elapsed counter, result register.
// Depends on bcr_pkg and bcr_div.
module bcr_dp #(
  parameter int ROM_BANK_BYTES = bcr_pkg::ROM_BANK_BYTES,
  parameter int RAM_BANK_BYTES = bcr_pkg::RAM_BANK_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bcr_pkg::cmd_t       cmd,
  input  bcr_pkg::in_item_t   in_item,
  output bcr_pkg::sts_t       sts,
  output logic                out_valid,
  output bcr_pkg::out_item_t  out_item
);

  localparam int ROM_OFS_W = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFS_W = $clog2(RAM_BANK_BYTES);

  bcr_pkg::in_item_t  item_r;
  bcr_pkg::out_item_t out_item_r, out_nxt;
  logic               out_valid_r;

  logic [6:0]  rom_bank_r, rom_bank_nxt;
  logic        ram_en_r, ram_en_nxt;
  logic        rtc_mode_r, rtc_mode_nxt;
  logic [1:0]  ram_bank_r, ram_bank_nxt;
  logic [2:0]  rtc_idx_r, rtc_idx_nxt;
  logic        last_one_r, last_one_nxt;
  logic        halted_r, halted_nxt;
  logic [7:0]  sec_r, sec_nxt;
  logic [7:0]  min_r, min_nxt;
  logic [7:0]  hr_r, hr_nxt;
  logic [7:0]  day_r, day_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;

  logic [bcr_pkg::PART_W-1:0]  part_r;
  logic [bcr_pkg::DAYP_W-1:0]  dayp_r;
  logic [bcr_pkg::TOTAL_W-1:0] div_in, quot;
  logic [bcr_pkg::REM_W-1:0]   rem;
  logic                        div_done;
  logic [7:0]                  rtc_rd;
  logic [7:0]                  wv;
  logic [2:0]                  region;
  logic                        in_ram_win;

  bcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.ld_sec || cmd.ld_min || cmd.ld_hr),
    .sel_day  (cmd.ld_hr),
    .step     (cmd.step),
    .dividend (div_in),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign div_in = cmd.ld_sec
      ? bcr_pkg::TOTAL_W'(elapsed_r) + bcr_pkg::TOTAL_W'(part_r) + bcr_pkg::TOTAL_W'(dayp_r)
      : quot;

  assign wv         = item_r.write_data;
  assign region     = item_r.address[15:13];
  assign in_ram_win = (region == 3'b101);

  always_comb begin
    case (rtc_idx_r)
      bcr_pkg::RTC_SEC: rtc_rd = sec_r;
      bcr_pkg::RTC_MIN: rtc_rd = min_r;
      bcr_pkg::RTC_HR:  rtc_rd = hr_r;
      bcr_pkg::RTC_DAY: rtc_rd = day_r;
      bcr_pkg::RTC_CTL: rtc_rd = ctl_r;
      default:          rtc_rd = bcr_pkg::BYTE_ONES;
    endcase
  end

  assign sts.latch_go = (item_r.func == bcr_pkg::FUNC_WRITE) && (region == 3'b011) &&
                        (wv == bcr_pkg::LATCH_ONE) && !last_one_r && !halted_r;
  assign sts.div_done = div_done;

  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_en_nxt   = ram_en_r;
    rtc_mode_nxt = rtc_mode_r;
    ram_bank_nxt = ram_bank_r;
    rtc_idx_nxt  = rtc_idx_r;
    last_one_nxt = last_one_r;
    halted_nxt   = halted_r;
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hr_nxt       = hr_r;
    day_nxt      = day_r;
    ctl_nxt      = ctl_r;
    elapsed_nxt  = elapsed_r;
    out_nxt      = '0;

    if (cmd.exec) begin
      case (item_r.func)
        bcr_pkg::FUNC_READ: begin
          if (item_r.address[15:14] == 2'b00) begin
            out_nxt.target      = bcr_pkg::TGT_ROM_RD;
            out_nxt.mem_address = bcr_pkg::MEM_ADDR_W'(item_r.address);
          end else if (item_r.address[15:14] == 2'b01) begin
            out_nxt.target      = bcr_pkg::TGT_ROM_RD;
            out_nxt.mem_address = bcr_pkg::MEM_ADDR_W'(
                {rom_bank_r, item_r.address[ROM_OFS_W-1:0]});
          end else if (in_ram_win) begin
            if (!ram_en_r) begin
              out_nxt.data = bcr_pkg::BYTE_ONES;
            end else if (!rtc_mode_r) begin
              out_nxt.target      = bcr_pkg::TGT_RAM_RD;
              out_nxt.mem_address = bcr_pkg::MEM_ADDR_W'(
                  {ram_bank_r, item_r.address[RAM_OFS_W-1:0]});
            end else begin
              out_nxt.data = rtc_rd;
            end
          end
        end
        bcr_pkg::FUNC_WRITE: begin
          case (region)
            3'b000: ram_en_nxt = (wv[3:0] == bcr_pkg::RAM_EN_KEY);
            3'b001: begin
              rom_bank_nxt = (wv[6:0] & bcr_pkg::ROM_BANK_MSK) == 7'd0 ? 7'd1
                                                                       : wv[6:0];
            end
            3'b010: begin
              if (wv <= bcr_pkg::RAM_BANK_MAX) begin
                rtc_mode_nxt = 1'b0;
                ram_bank_nxt = wv[1:0];
              end else if (wv >= bcr_pkg::RTC_SEL_LO && wv <= bcr_pkg::RTC_SEL_HI) begin
                rtc_mode_nxt = 1'b1;
                rtc_idx_nxt  = wv[2:0];
              end
            end
            3'b011: last_one_nxt = (wv == bcr_pkg::LATCH_ONE);
            3'b101: begin
              if (ram_en_r) begin
                if (!rtc_mode_r) begin
                  out_nxt.target      = bcr_pkg::TGT_RAM_WR;
                  out_nxt.mem_address = bcr_pkg::MEM_ADDR_W'(
                      {ram_bank_r, item_r.address[RAM_OFS_W-1:0]});
                  out_nxt.data        = wv;
                end else if (rtc_idx_r <= bcr_pkg::RTC_CTL) begin
                  elapsed_nxt = '0;
                  case (rtc_idx_r)
                    bcr_pkg::RTC_SEC: sec_nxt = (wv > bcr_pkg::SEC_MAX) ? bcr_pkg::SEC_MAX : wv;
                    bcr_pkg::RTC_MIN: min_nxt = (wv > bcr_pkg::SEC_MAX) ? bcr_pkg::SEC_MAX : wv;
                    bcr_pkg::RTC_HR:  hr_nxt  = (wv > bcr_pkg::HR_MAX) ? bcr_pkg::HR_MAX : wv;
                    bcr_pkg::RTC_DAY: day_nxt = wv;
                    default: begin
                      halted_nxt = (wv & bcr_pkg::HALT_MSK) != 8'd0;
                      ctl_nxt    = wv & bcr_pkg::HALT_MSK;
                    end
                  endcase
                end
              end
            end
            default: ;
          endcase
        end
        bcr_pkg::FUNC_TICK: begin
          if (elapsed_r != 32'hFFFF_FFFF) elapsed_nxt = elapsed_r + 32'd1;
        end
        default: ;
      endcase
    end

    // Latch pass: store each remainder as its division finishes.
    if (cmd.ld_min) sec_nxt = 8'(rem);
    if (cmd.ld_hr)  min_nxt = 8'(rem);
    if (cmd.commit) begin
      hr_nxt      = 8'(rem);
      day_nxt     = '0;
      ctl_nxt     = '0;
      elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r  <= 7'd1;
      ram_en_r    <= 1'b0;
      rtc_mode_r  <= 1'b0;
      ram_bank_r  <= '0;
      rtc_idx_r   <= '0;
      last_one_r  <= 1'b0;
      halted_r    <= 1'b0;
      sec_r       <= '0;
      min_r       <= '0;
      hr_r        <= '0;
      day_r       <= '0;
      ctl_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rom_bank_r  <= rom_bank_nxt;
      ram_en_r    <= ram_en_nxt;
      rtc_mode_r  <= rtc_mode_nxt;
      ram_bank_r  <= ram_bank_nxt;
      rtc_idx_r   <= rtc_idx_nxt;
      last_one_r  <= last_one_nxt;
      halted_r    <= halted_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hr_r        <= hr_nxt;
      day_r       <= day_nxt;
      ctl_r       <= ctl_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.emit) out_item_r <= out_nxt;
    if (cmd.sum) begin
      part_r <= bcr_pkg::PART_W'(sec_r) +
                bcr_pkg::PART_W'(min_r) * bcr_pkg::PART_W'(bcr_pkg::SEC_PER_MIN) +
                bcr_pkg::PART_W'(hr_r) * bcr_pkg::PART_W'(bcr_pkg::SEC_PER_HR);
      dayp_r <= bcr_pkg::DAYP_W'(day_r) * bcr_pkg::DAYP_W'(bcr_pkg::SEC_PER_DAY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== tb/bank_controller_with_rtc_top_tb.sv =====
// Self-checking testbench for bank_controller_with_rtc_top: directed and random
// bus beats, each result checked against an in-bench prediction of the mapper.
// Depends on bcr_pkg and the RTL of bank_controller_with_rtc_top.
module bank_controller_with_rtc_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcr_pkg::*;

  // Function code the block must ignore.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_BEATS = 1900;
  // The slowest legal run is far below this, even with every beat a latch
  // and every send gap at its longest.
  localparam int CYCLE_LIMIT  = 800000;
  // A latch is the longest operation; let a window longer than one latch pass after the drain.
  localparam int SETTLE_CYCLES = 120;

  // Mapper and clock prediction plus the queue of results still to arrive.
  class bank_scoreboard;
    logic [6:0]  rom_bank;
    logic        ram_on;
    logic        clock_mode;
    logic [1:0]  ram_bank;
    logic [2:0]  clock_sel;
    logic        latch_one;
    logic        halted;
    logic [7:0]  clock_regs [5];
    logic [31:0] elapsed;
    out_item_t   expected_q [$];
    int          errors;

    function new();
      rom_bank   = 7'd1;
      ram_on     = 1'b0;
      clock_mode = 1'b0;
      ram_bank   = '0;
      clock_sel  = RTC_SEC;
      latch_one  = 1'b0;
      halted     = 1'b0;
      foreach (clock_regs[i]) clock_regs[i] = '0;
      elapsed    = '0;
      errors     = 0;
    endfunction

    // Advance the prediction by one accepted beat and queue its result.
    function void note_beat(in_item_t b);
      out_item_t   r;
      logic [15:0] a;
      logic [7:0]  v;
      logic [63:0] total;
      a = b.address;
      v = b.write_data;
      r = '0;
      r.target = TGT_LOCAL;
      case (b.func)
        FUNC_READ: begin
          if (a < 16'h4000) begin
            r.target = TGT_ROM_RD;
            r.mem_address = {5'd0, a};
          end else if (a < 16'h8000) begin
            r.target = TGT_ROM_RD;
            r.mem_address = {rom_bank, a[13:0]};
          end else if (a >= 16'hA000 && a < 16'hC000) begin
            if (!ram_on) begin
              r.data = BYTE_ONES;
            end else if (!clock_mode) begin
              r.target = TGT_RAM_RD;
              r.mem_address = {6'd0, ram_bank, a[12:0]};
            end else begin
              r.data = (clock_sel <= RTC_CTL) ? clock_regs[clock_sel] : BYTE_ONES;
            end
          end
        end
        FUNC_WRITE: begin
          if (a < 16'h2000) begin
            ram_on = (v[3:0] == RAM_EN_KEY);
          end else if (a < 16'h4000) begin
            rom_bank = (v[6:0] == 7'd0) ? 7'd1 : (v[6:0] & ROM_BANK_MSK);
          end else if (a < 16'h6000) begin
            if (v <= RAM_BANK_MAX) begin
              clock_mode = 1'b0;
              ram_bank   = v[1:0];
            end else if (v >= RTC_SEL_LO && v <= RTC_SEL_HI) begin
              clock_mode = 1'b1;
              clock_sel  = v[2:0];
            end
          end else if (a < 16'h8000) begin
            // Latch on a 1 that follows anything else; a halted clock holds.
            if (v == LATCH_ONE && !latch_one && !halted) begin
              total = 64'(clock_regs[RTC_SEC]) +
                      64'(clock_regs[RTC_MIN]) * SEC_PER_MIN +
                      64'(clock_regs[RTC_HR])  * SEC_PER_HR +
                      64'(clock_regs[RTC_DAY]) * SEC_PER_DAY +
                      64'(elapsed);
              clock_regs[RTC_SEC] = 8'(total % SEC_PER_MIN);
              clock_regs[RTC_MIN] = 8'((total / SEC_PER_MIN) % SEC_PER_MIN);
              clock_regs[RTC_HR]  = 8'((total / SEC_PER_HR) % (SEC_PER_DAY / SEC_PER_HR));
              clock_regs[RTC_DAY] = '0;
              clock_regs[RTC_CTL] = '0;
              elapsed = '0;
            end
            latch_one = (v == LATCH_ONE);
          end else if (a >= 16'hA000 && a < 16'hC000 && ram_on) begin
            if (!clock_mode) begin
              r.target = TGT_RAM_WR;
              r.mem_address = {6'd0, ram_bank, a[12:0]};
              r.data = v;
            end else if (clock_sel <= RTC_CTL) begin
              elapsed = '0;
              case (clock_sel)
                RTC_SEC, RTC_MIN: clock_regs[clock_sel] = (v > SEC_MAX) ? SEC_MAX : v;
                RTC_HR:           clock_regs[RTC_HR] = (v > HR_MAX) ? HR_MAX : v;
                RTC_DAY:          clock_regs[RTC_DAY] = v;
                default: begin
                  halted = (v & HALT_MSK) != 0;
                  clock_regs[RTC_CTL] = v & HALT_MSK;
                end
              endcase
            end
          end
        end
        FUNC_TICK: begin
          if (elapsed != '1) elapsed++;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    // Compare one strobed result with the oldest queued one, field by field.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: target %0d mem_address %h data %h",
                 $time, got.target, got.mem_address, got.data);
        return;
      end
      want = expected_q.pop_front();
      if (got.target !== want.target) begin
        errors++;
        $display("%0t: target expected %0d actual %0d", $time, want.target, got.target);
      end
      if (got.mem_address !== want.mem_address) begin
        errors++;
        $display("%0t: mem_address expected %h actual %h",
                 $time, want.mem_address, got.mem_address);
      end
      if (got.data !== want.data) begin
        errors++;
        $display("%0t: data expected %h actual %h", $time, want.data, got.data);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  bank_scoreboard sb;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;

  bank_controller_with_rtc_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every strobed result; the block cannot be held off, so take them all.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  function automatic in_item_t make_beat(logic [1:0] f, logic [15:0] a, logic [7:0] d);
    in_item_t b;
    b.func       = f;
    b.address    = a;
    b.write_data = d;
    return b;
  endfunction

  function automatic logic [15:0] pick_addr(logic [15:0] base, int span);
    return 16'(base + $urandom_range(0, span - 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Drop start and scramble the idle payload.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= make_beat(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                           rand_byte());
    end
  endtask

  // Present one beat and hold it until the block takes it. Bursts of random
  // length alternate with random gaps; some bursts follow with no gap at all.
  task automatic send_beat(in_item_t b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
    sb.note_beat(b);
    sent++;
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // One well-formed access sequence with random content, or a noise beat.
  // Returns 1 when the sequence was plain noise.
  task automatic run_random_sequence(output bit was_noise);
    int pick;
    int n;
    int idx;
    was_noise = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 4))
        0: send_beat(make_beat(FUNC_READ, pick_addr(16'h0000, 16'h4000), rand_byte()));
        1: send_beat(make_beat(FUNC_READ, pick_addr(16'h4000, 16'h4000), rand_byte()));
        2: send_beat(make_beat(FUNC_READ, pick_addr(16'hA000, 16'h2000), rand_byte()));
        3: send_beat(make_beat(FUNC_READ, pick_addr(16'h8000, 16'h2000), rand_byte()));
        default: send_beat(make_beat(FUNC_READ, pick_addr(16'hC000, 16'h4000), rand_byte()));
      endcase
    end else if (pick < 28) begin
      // Mostly the enable key, with random upper nibble.
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h0000, 16'h2000),
                          {4'($urandom_range(0, 15)),
                           ($urandom_range(0, 9) < 7) ? RAM_EN_KEY
                                                      : 4'($urandom_range(0, 15))}));
    end else if (pick < 35) begin
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h2000, 16'h2000),
                          ($urandom_range(0, 4) == 0) ? {$urandom_range(0, 1) == 1, 7'd0}
                                                      : rand_byte()));
    end else if (pick < 45) begin
      case ($urandom_range(0, 4))
        0, 1: n = $urandom_range(0, RAM_BANK_MAX);
        2, 3: n = $urandom_range(RTC_SEL_LO, RTC_SEL_HI);
        default: n = $urandom_range(0, 255);
      endcase
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h4000, 16'h2000), 8'(n)));
    end else if (pick < 55) begin
      // Select a clock register, then write it: in range, clamped or halt bit.
      idx = $urandom_range(RTC_SEC, RTC_CTL);
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h4000, 16'h2000), 8'(RTC_SEL_LO + idx)));
      case ($urandom_range(0, 2))
        0: n = $urandom_range(0, HR_MAX);
        1: n = $urandom_range(0, 255);
        default: n = ($urandom_range(0, 1) == 1) ? HALT_MSK : 0;
      endcase
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'hA000, 16'h2000), 8'(n)));
    end else if (pick < 68) begin
      // Latch: a zero or random byte then a one, sometimes a repeated one; then sometimes read back.
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h6000, 16'h2000),
                          ($urandom_range(0, 3) == 0) ? rand_byte() : 8'h00));
      send_beat(make_beat(FUNC_WRITE, pick_addr(16'h6000, 16'h2000), LATCH_ONE));
      if ($urandom_range(0, 3) == 0)
        send_beat(make_beat(FUNC_WRITE, pick_addr(16'h6000, 16'h2000), LATCH_ONE));
      if ($urandom_range(0, 1) == 1) begin
        for (idx = RTC_SEC; idx <= RTC_CTL; idx++) begin
          send_beat(make_beat(FUNC_WRITE, pick_addr(16'h4000, 16'h2000),
                              8'(RTC_SEL_LO + idx)));
          send_beat(make_beat(FUNC_READ, pick_addr(16'hA000, 16'h2000), rand_byte()));
        end
      end
    end else if (pick < 84) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      repeat (n) send_beat(make_beat(FUNC_TICK, 16'($urandom_range(0, 65535)), rand_byte()));
    end else if (pick < 95) begin
      send_beat(make_beat(($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ,
                          pick_addr(16'hA000, 16'h2000), rand_byte()));
    end else begin
      was_noise = 1'b1;
      send_beat(make_beat(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                          rand_byte()));
    end
  endtask

  initial begin
    in_item_t directed [$];
    int       useful;
    int       mark;
    bit       noise;

    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: address extremes, every function, clamps, halt, latch edges.
    directed.push_back(make_beat(FUNC_READ,  16'h0000, 8'h00));
    directed.push_back(make_beat(FUNC_READ,  16'h7FFF, 8'hFF));  // reset bank is 1
    directed.push_back(make_beat(FUNC_READ,  16'hA000, 8'h00));  // RAM off answers ones
    directed.push_back(make_beat(FUNC_READ,  16'hFFFF, 8'h00));  // unmapped answers zero
    directed.push_back(make_beat(FUNC_WRITE, 16'h1FFF, 8'hFA));  // enable RAM
    directed.push_back(make_beat(FUNC_WRITE, 16'h2000, 8'h80));  // masked zero picks 1
    directed.push_back(make_beat(FUNC_WRITE, 16'h3FFF, 8'hFF));  // top ROM bank
    directed.push_back(make_beat(FUNC_READ,  16'h7FFF, 8'h00));  // highest ROM address
    directed.push_back(make_beat(FUNC_WRITE, 16'h4000, 8'h03));
    directed.push_back(make_beat(FUNC_WRITE, 16'hBFFF, 8'hA5));  // RAM write
    directed.push_back(make_beat(FUNC_READ,  16'hBFFF, 8'h00));
    directed.push_back(make_beat(FUNC_WRITE, 16'h5FFF, 8'h0B));  // select day
    directed.push_back(make_beat(FUNC_WRITE, 16'hA000, 8'hFF));
    directed.push_back(make_beat(FUNC_WRITE, 16'h4000, 8'h0A));  // select hours
    directed.push_back(make_beat(FUNC_WRITE, 16'hA000, 8'hFF));  // clamps at 23
    directed.push_back(make_beat(FUNC_WRITE, 16'h4000, 8'h0C));  // select control
    directed.push_back(make_beat(FUNC_WRITE, 16'hA000, 8'hFF));  // halt
    directed.push_back(make_beat(FUNC_WRITE, 16'h7FFF, 8'h01));  // latch while halted
    directed.push_back(make_beat(FUNC_WRITE, 16'hA000, 8'h00));  // run again
    directed.push_back(make_beat(FUNC_TICK,  16'hFFFF, 8'hFF));
    directed.push_back(make_beat(FUNC_WRITE, 16'h6000, 8'h00));
    directed.push_back(make_beat(FUNC_WRITE, 16'h6000, 8'h01));  // latch fires
    directed.push_back(make_beat(FUNC_WRITE, 16'h4000, 8'h08));  // select seconds
    directed.push_back(make_beat(FUNC_READ,  16'hA000, 8'h00));  // folded seconds
    directed.push_back(make_beat(FUNC_SPARE, 16'hFFFF, 8'hFF));
    foreach (directed[i]) send_beat(directed[i]);
    drain_results();

    // Random: mostly well-formed sequences, with one forced drain midway and occasional random drains.
    useful = 0;
    while (useful < RANDOM_BEATS) begin
      mark = sent;
      run_random_sequence(noise);
      if (!noise) useful += sent - mark;
      if (useful >= RANDOM_BEATS / 2 && useful - (sent - mark) < RANDOM_BEATS / 2)
        drain_results();
      else if ($urandom_range(0, 199) == 0)
        drain_results();
    end

    // Drain, let a window longer than a latch pass for stray strobes, then report.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
